>>> rtl/stereo_biquad_filter_unit_macros.svh
// Assertion helpers shared by the filter RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef STEREO_BIQUAD_FILTER_UNIT_MACROS_SVH
`define STEREO_BIQUAD_FILTER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define SBQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sbq assertion failed");

// Next-cycle implication, disabled during reset
`define SBQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sbq assertion failed");

`else

`define SBQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SBQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> rtl/sbq_pkg.sv
`timescale 1ns / 1ps

package sbq_pkg;

    // Default datapath widths
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int COEF_WIDTH_DEF   = 32;

    // Coefficient register file
    localparam int CFG_INDEX_WIDTH = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_FEED_ZERO = 2'd0,  // b0, also used as b2
        REG_FEED_ONE  = 2'd1,  // b1
        REG_BACK_ONE  = 2'd2,  // a1
        REG_BACK_TWO  = 2'd3   // a2
    } t_cfg_reg;

endpackage

>>> rtl/sbq_channel.sv
`timescale 1ns / 1ps

// One channel of the direct-form-1 section:
//   y = sat(round((b0*x + b1*x1 + b0*x2 - a1*y1 - a2*y2) / 2^(CW-2)))
// Five products in parallel, exact sum, round half up, saturate.
module sbq_channel #(
    parameter int SAMPLE_WIDTH = sbq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = sbq_pkg::COEF_WIDTH_DEF
) (
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x1,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x2,
    input  logic signed [SAMPLE_WIDTH-1:0] i_y1,
    input  logic signed [SAMPLE_WIDTH-1:0] i_y2,
    input  logic signed [COEF_WIDTH-1:0]   i_b0,
    input  logic signed [COEF_WIDTH-1:0]   i_b1,
    input  logic signed [COEF_WIDTH-1:0]   i_a1,
    input  logic signed [COEF_WIDTH-1:0]   i_a2,
    output logic signed [SAMPLE_WIDTH-1:0] o_y,
    output logic                           o_sat
);

    // Negated feedback coefficients need one extra bit (-(-2^(CW-1)))
    localparam int CF_W  = COEF_WIDTH + 1;
    localparam int PRD_W = SAMPLE_WIDTH + CF_W;
    localparam int ACC_W = PRD_W + 3;
    localparam int FRAC  = COEF_WIDTH - 2;
    localparam int Q_W   = ACC_W - FRAC;

    localparam logic [ACC_W-1:0] ROUND_BIAS = {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC - 1);
    localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [CF_W-1:0]  w_c0, w_c1, w_c3, w_c4;
    logic signed [PRD_W-1:0] w_p0, w_p1, w_p2, w_p3, w_p4;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [ACC_W-1:0] w_rnd;
    logic signed [Q_W-1:0]   w_q;

    // Coefficients: feed terms extended, feedback terms negated
    assign w_c0 = CF_W'(i_b0);
    assign w_c1 = CF_W'(i_b1);
    assign w_c3 = -CF_W'(i_a1);
    assign w_c4 = -CF_W'(i_a2);

    // Five products, exact width
    assign w_p0 = PRD_W'(i_x)  * PRD_W'(w_c0);
    assign w_p1 = PRD_W'(i_x1) * PRD_W'(w_c1);
    assign w_p2 = PRD_W'(i_x2) * PRD_W'(w_c0);
    assign w_p3 = PRD_W'(i_y1) * PRD_W'(w_c3);
    assign w_p4 = PRD_W'(i_y2) * PRD_W'(w_c4);

    // Exact accumulation
    assign w_acc = ACC_W'(w_p0) + ACC_W'(w_p1) + ACC_W'(w_p2)
                 + ACC_W'(w_p3) + ACC_W'(w_p4);

    // Round half up, then drop fraction bits (floor)
    assign w_rnd = w_acc + $signed(ROUND_BIAS);
    assign w_q   = w_rnd[ACC_W-1:FRAC];

    // Clamp to the sample range
    always_comb begin
        if (w_q > Q_W'(SMP_MAX)) begin
            o_y   = SMP_MAX;
            o_sat = 1'b1;
        end else if (w_q < Q_W'(SMP_MIN)) begin
            o_y   = SMP_MIN;
            o_sat = 1'b1;
        end else begin
            o_y   = w_q[SAMPLE_WIDTH-1:0];
            o_sat = 1'b0;
        end
    end

endmodule

>>> rtl/stereo_biquad_filter_unit.sv
`timescale 1ns / 1ps
`include "stereo_biquad_filter_unit_macros.svh"

// Stereo biquad filter (direct form 1), one shared coefficient set.
// Channels:
//   input   i_in_valid / o_in_ready, payload i_left_in, i_right_in
//   output  o_out_valid / i_out_ready, payload o_left_out, o_right_out, o_clipped
//   config  i_cfg_valid / o_cfg_ready (always ready), i_cfg_index, i_cfg_data;
//           index 0 = b0 (also b2), 1 = b1, 2 = a1, 3 = a2, all signed Q2.(CW-2).
//           Write coefficients only while no request is in flight.
// Timing: an accepted request is held in the input register, then the filter math
// for both channels runs combinationally into the output register. One request
// per cycle is sustained while the output is not stalled; the feedback path
// (five multiplies plus sum, round and clamp feeding the y1 history) is the
// combinational loop through the y1 register that sets this rate.
// Stall: while o_out_valid is high and i_out_ready low, the result holds; the
// input register can still take one more request, then o_in_ready drops.
// Reset (synchronous, active low): coefficients and all sample history clear
// to zero, both valid flags clear.
module stereo_biquad_filter_unit #(
    parameter int SAMPLE_WIDTH = sbq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = sbq_pkg::COEF_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sbq_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [COEF_WIDTH-1:0]               i_cfg_data,
    // sample input
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_left_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_right_in,
    // filtered output
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      o_left_out,
    output logic signed [SAMPLE_WIDTH-1:0]      o_right_out,
    output logic                                o_clipped
);

    import sbq_pkg::*;

    localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // Coefficients
    logic signed [COEF_WIDTH-1:0] r_b0, r_b1, r_a1, r_a2;

    // Input register (index 0 = left, 1 = right)
    logic                           r_in_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_in [2];

    // Per-channel history
    logic signed [SAMPLE_WIDTH-1:0] r_x1 [2];
    logic signed [SAMPLE_WIDTH-1:0] r_x2 [2];
    logic signed [SAMPLE_WIDTH-1:0] r_y1 [2];
    logic signed [SAMPLE_WIDTH-1:0] r_y2 [2];

    // Output register
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out [2];
    logic                           r_clip;

    logic                           n_out_valid;
    logic                           n_in_valid;
    logic                           w_advance;
    logic                           w_in_take;
    logic signed [SAMPLE_WIDTH-1:0] w_y [2];
    logic                           w_sat [2];

    // Handshake: compute stage moves when the output slot is free or draining
    assign w_advance   = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready  = ~r_in_valid | w_advance;
    assign w_in_take   = i_in_valid & o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_take) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Coefficient writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= '0;
            r_b1 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_FEED_ZERO: r_b0 <= i_cfg_data;
                REG_FEED_ONE:  r_b1 <= i_cfg_data;
                REG_BACK_ONE:  r_a1 <= i_cfg_data;
                REG_BACK_TWO:  r_a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Input sample capture
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in[0] <= i_left_in;
            r_in[1] <= i_right_in;
        end
    end

    // Filter datapath and history, one instance per channel
    for (genvar c = 0; c < 2; c++) begin : g_chan
        sbq_channel #(
            .SAMPLE_WIDTH(SAMPLE_WIDTH),
            .COEF_WIDTH  (COEF_WIDTH)
        ) u_chan (
            .i_x  (r_in[c]),
            .i_x1 (r_x1[c]),
            .i_x2 (r_x2[c]),
            .i_y1 (r_y1[c]),
            .i_y2 (r_y2[c]),
            .i_b0 (r_b0),
            .i_b1 (r_b1),
            .i_a1 (r_a1),
            .i_a2 (r_a2),
            .o_y  (w_y[c]),
            .o_sat(w_sat[c])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_x1[c] <= '0;
                r_x2[c] <= '0;
                r_y1[c] <= '0;
                r_y2[c] <= '0;
            end else if (w_advance) begin
                r_x1[c] <= r_in[c];
                r_x2[c] <= r_x1[c];
                r_y1[c] <= w_y[c];
                r_y2[c] <= r_y1[c];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_advance) begin
                r_out[c] <= w_y[c];
            end
        end
    end

    // Clip flag rides with the result
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_clip <= w_sat[0] | w_sat[1];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_out[0];
    assign o_right_out = r_out[1];
    assign o_clipped   = r_clip;

    // A clipped result has at least one channel sitting on a rail
    `SBQ_ASSERT_IMP(a_clip_on_rail, i_clk, i_rst_n, r_out_valid && r_clip,
        (r_out[0] == SMP_MAX) || (r_out[0] == SMP_MIN) ||
        (r_out[1] == SMP_MAX) || (r_out[1] == SMP_MIN))

    // Feedback history tracks exactly what was delivered to the output
    `SBQ_ASSERT_NXT(a_y1_matches_out, i_clk, i_rst_n, w_advance,
        (r_y1[0] == r_out[0]) && (r_y1[1] == r_out[1]))

    // Input history takes the sample that was just filtered
    `SBQ_ASSERT_NXT(a_x1_follows_in, i_clk, i_rst_n, w_advance,
        (r_x1[0] == $past(r_in[0])) && (r_x1[1] == $past(r_in[1])))

    // A computed result always lands in the output slot
    `SBQ_ASSERT_NXT(a_adv_fills_out, i_clk, i_rst_n, w_advance, r_out_valid)

endmodule

>>> test/stereo_biquad_filter_unit_checker.sv
`timescale 1ns / 1ps

// Watches the config, sample and result channels, runs a bit-exact biquad
// model on every accepted request and checks each result in order.
module stereo_biquad_filter_unit_checker #(
    parameter int SAMPLE_WIDTH = sbq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = sbq_pkg::COEF_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write channel
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [sbq_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [COEF_WIDTH-1:0]               i_cfg_data,
    // sample channel
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_left_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_right_in,
    // result channel
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_left_out,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_right_out,
    input  logic                                i_clipped,
    // status to the testbench top
    output int                                  o_mismatch_count,
    output int                                  o_pending_count
);
    import sbq_pkg::*;

    localparam int     FRAC_BITS  = COEF_WIDTH - 2;
    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam int     REPORT_MAX = 10;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left;
        logic signed [SAMPLE_WIDTH-1:0] right;
        logic                           clipped;
    } t_filt_result;

    // Shared coefficient set, sign-extended
    longint coef_b0;
    longint coef_b1;
    longint coef_a1;
    longint coef_a2;

    // Per-channel history, index 0 = left, 1 = right
    longint x_prev  [2];
    longint x_prev2 [2];
    longint y_prev  [2];
    longint y_prev2 [2];

    t_filt_result filtered_q[$];
    int           mismatches;

    // One channel of the direct-form-1 section: exact sum, round half up,
    // clamp, then shift the clamped value into the history.
    function automatic longint biquad_channel(input int ch, input longint x,
                                              output logic sat);
        longint acc;
        acc = coef_b0 * x + coef_b1 * x_prev[ch] + coef_b0 * x_prev2[ch]
            - coef_a1 * y_prev[ch] - coef_a2 * y_prev2[ch];
        acc = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        sat = 1'b0;
        if (acc > SAMPLE_MAX) begin
            acc = SAMPLE_MAX;
            sat = 1'b1;
        end else if (acc < SAMPLE_MIN) begin
            acc = SAMPLE_MIN;
            sat = 1'b1;
        end
        x_prev2[ch] = x_prev[ch];
        x_prev[ch]  = x;
        y_prev2[ch] = y_prev[ch];
        y_prev[ch]  = acc;
        return acc;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches = mismatches + 1;
        if (mismatches <= REPORT_MAX) begin
            $display("%0t: MISMATCH %s", $time, msg);
        end
    endtask

    // Config first, then new requests, then results, all on the same edge
    always @(posedge i_clk) begin
        t_filt_result want;
        logic         sat_left;
        logic         sat_right;
        if (!i_rst_n) begin
            coef_b0 = 0;
            coef_b1 = 0;
            coef_a1 = 0;
            coef_a2 = 0;
            for (int c = 0; c < 2; c++) begin
                x_prev[c]  = 0;
                x_prev2[c] = 0;
                y_prev[c]  = 0;
                y_prev2[c] = 0;
            end
            filtered_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_FEED_ZERO: coef_b0 = longint'($signed(i_cfg_data));
                    REG_FEED_ONE:  coef_b1 = longint'($signed(i_cfg_data));
                    REG_BACK_ONE:  coef_a1 = longint'($signed(i_cfg_data));
                    REG_BACK_TWO:  coef_a2 = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready) begin
                want.left    = SAMPLE_WIDTH'(biquad_channel(0, longint'(i_left_in),
                                                            sat_left));
                want.right   = SAMPLE_WIDTH'(biquad_channel(1, longint'(i_right_in),
                                                            sat_right));
                want.clipped = sat_left | sat_right;
                filtered_q.push_back(want);
            end

            if (i_out_valid && i_out_ready) begin
                if (filtered_q.size() == 0) begin
                    report_mismatch($sformatf("result with no request pending: %0d %0d %0b",
                                              i_left_out, i_right_out, i_clipped));
                end else begin
                    want = filtered_q.pop_front();
                    if (i_left_out !== want.left) begin
                        report_mismatch($sformatf("left_out: expected %0d, actual %0d",
                                                  want.left, i_left_out));
                    end
                    if (i_right_out !== want.right) begin
                        report_mismatch($sformatf("right_out: expected %0d, actual %0d",
                                                  want.right, i_right_out));
                    end
                    if (i_clipped !== want.clipped) begin
                        report_mismatch($sformatf("clipped: expected %0b, actual %0b",
                                                  want.clipped, i_clipped));
                    end
                end
            end
        end
        o_pending_count  <= filtered_q.size();
        o_mismatch_count <= mismatches;
    end

endmodule

>>> test/stereo_biquad_filter_unit_tb.sv
`timescale 1ns / 1ps

module stereo_biquad_filter_unit_tb;
    import sbq_pkg::*;

    localparam int SW             = SAMPLE_WIDTH_DEF;
    localparam int CW             = COEF_WIDTH_DEF;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_REQUESTS = 120;

    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW - 1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW - 1){1'b0}}};

    // Q2.30 reference points
    localparam logic [CW-1:0] C_ZERO    = '0;
    localparam logic [CW-1:0] C_HALF    = 32'h2000_0000;
    localparam logic [CW-1:0] C_ONE     = 32'h4000_0000;
    localparam logic [CW-1:0] C_NEG_ONE = 32'hC000_0000;
    localparam logic [CW-1:0] C_MAX     = 32'h7FFF_FFFF;
    localparam logic [CW-1:0] C_MIN     = 32'h8000_0000;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [CW-1:0]              i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic signed [SW-1:0]       i_left_in;
    logic signed [SW-1:0]       i_right_in;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic signed [SW-1:0]       o_left_out;
    logic signed [SW-1:0]       o_right_out;
    logic                       o_clipped;

    int mismatch_count;
    int pending_count;
    int in_gap_pct;
    int out_stall_pct;
    int cycle_count = 0;

    stereo_biquad_filter_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_left_in   (i_left_in),
        .i_right_in  (i_right_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out),
        .o_clipped   (o_clipped)
    );

    stereo_biquad_filter_unit_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_left_in        (i_left_in),
        .i_right_in       (i_right_in),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_left_out       (o_left_out),
        .i_right_out      (o_right_out),
        .i_clipped        (o_clipped),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return S_MAX;
            1: return S_MIN;
            2, 3: return SW'($signed($urandom_range(0, 1024)) - 512);
            4: return '0;
            default: return SW'($urandom());
        endcase
    endfunction

    // Result-side back-pressure
    initial begin
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left  = stall_left - 1;
                i_out_ready = 1'b0;
            end else if ($urandom_range(0, 99) < out_stall_pct) begin
                stall_left  = pick_gap() - 1;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // One sample pair request; returns at a falling edge
    task automatic send_sample(input logic signed [SW-1:0] left,
                               input logic signed [SW-1:0] right);
        i_left_in  = left;
        i_right_in = right;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < in_gap_pct) begin
            i_in_valid = 1'b0;
            repeat (pick_gap()) @(negedge i_clk);
        end
    endtask

    task automatic write_coef(input t_cfg_reg idx, input logic [CW-1:0] value);
        i_cfg_index = idx;
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_coefs(input logic [CW-1:0] b0, input logic [CW-1:0] b1,
                              input logic [CW-1:0] a1, input logic [CW-1:0] a2);
        write_coef(REG_FEED_ZERO, b0);
        write_coef(REG_FEED_ONE, b1);
        write_coef(REG_BACK_ONE, a1);
        write_coef(REG_BACK_TWO, a2);
    endtask

    // Wait until every result is out, then add a margin
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Random coefficient set: either a stable low-gain section or raw bits
    task automatic load_random_coefs(input bit raw);
        longint a2;
        longint a1_lim;
        longint a1;
        longint b0;
        longint b1;
        if (raw) begin
            load_coefs(CW'($urandom()), CW'($urandom()), CW'($urandom()), CW'($urandom()));
        end else begin
            a2     = longint'($urandom_range(0, 32'h2E66_6666));
            a1_lim = ((longint'(1) <<< 30) + a2) * 9 / 10;
            a1     = longint'($urandom_range(0, 32'(2 * a1_lim))) - a1_lim;
            b0     = longint'($urandom_range(0, 32'h4000_0000)) - 64'sh2000_0000;
            b1     = longint'($urandom_range(0, 32'h8000_0000)) - 64'sh4000_0000;
            load_coefs(CW'(b0), CW'(b1), CW'(a1), CW'(a2));
        end
    endtask

    // Main stimulus
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_FEED_ZERO;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_left_in     = '0;
        i_right_in    = '0;
        in_gap_pct    = 0;
        out_stall_pct = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Coefficients at reset value: everything filters to zero
        send_sample(S_MAX, S_MIN);
        send_sample(1, -1);
        wait_drained();

        // Half-LSB rounding in both directions, then saturation via b1
        load_coefs(C_HALF, C_ONE, C_ZERO, C_ZERO);
        send_sample(1, -1);
        send_sample(1, -1);
        send_sample(0, 0);
        send_sample(-1, 1);
        send_sample(S_MAX, S_MIN);
        send_sample(S_MAX, S_MIN);
        send_sample(S_MAX, S_MAX);
        wait_drained();

        // Unity b0 (also b2) plus feedback: y = x + x2 + y1 - y2 style oscillation
        load_coefs(C_ONE, C_ZERO, C_NEG_ONE, C_ONE);
        send_sample(S_MAX, 3);
        send_sample(0, 0);
        send_sample(0, 0);
        send_sample(S_MIN, -5);
        send_sample(0, 0);
        wait_drained();

        // Coefficient extremes, one-sided and two-sided clipping
        load_coefs(C_MAX, C_MIN, C_MIN, C_MAX);
        send_sample(S_MAX, S_MIN);
        send_sample(S_MIN, S_MAX);
        send_sample(S_MAX, 0);
        send_sample(0, 1);
        send_sample(S_MIN, S_MIN);
        send_sample(0, 0);
        wait_drained();

        // Random phases, each with its own coefficients and idling mix
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            load_random_coefs(p % 3 == 2);
            in_gap_pct    = (p == 0) ? 0 : pick_pct();
            out_stall_pct = (p == 0) ? 0 : pick_pct();
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                send_sample(pick_sample(), pick_sample());
            end
            wait_drained();
        end

        in_gap_pct    = 0;
        out_stall_pct = 0;
        repeat (16) @(negedge i_clk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
